// ===== hw/rtl/wsp_pkg.sv =====
// Shared types and constants of the wheel speed PID controller.
package wsp_pkg;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned GainW    = 16;
  localparam int unsigned DutyW    = 15;
  localparam int unsigned SpeedW   = 16;
  localparam int unsigned TargetW  = 17;
  localparam int unsigned ErrW     = 24;
  localparam int unsigned D2W      = 26;
  localparam int unsigned MeasW    = 27;
  localparam int unsigned DiffW    = 28;
  localparam int unsigned MeasShift = 6;
  localparam int unsigned IsumW    = 46;
  localparam int unsigned IsumSplit = 23;
  localparam int unsigned MacAW    = 17;
  localparam int unsigned MacBW    = 27;
  localparam int unsigned MacPW    = MacAW + MacBW;
  localparam int unsigned AccW     = 64;
  localparam int unsigned DivShift = 10;
  localparam int unsigned DriveW   = AccW - DivShift;

  localparam logic [CfgIdxW-1:0] CFG_PROP_GAIN   = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_INTEG_GAIN  = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_DERIV_GAIN  = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_SPEED_SCALE = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_OFFSET_SIGN = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_DUTY_LIMIT  = 3'd5;

  typedef struct packed {
    logic en;
    logic clear;
    logic shift_hi;
  } mac_ctrl_t;

endpackage

// ===== hw/rtl/wsp_mac.sv =====
// Shared signed multiply-accumulate unit with an optional high-half shift.
module wsp_mac (
  input  logic                                  clk_i,
  input  wsp_pkg::mac_ctrl_t                    ctrl_i,
  input  logic signed [wsp_pkg::MacAW-1:0]      a_i,
  input  logic signed [wsp_pkg::MacBW-1:0]      b_i,
  output logic signed [wsp_pkg::AccW-1:0]       acc_o
);
  import wsp_pkg::*;

  logic signed [MacPW-1:0] prod;
  logic signed [AccW-1:0]  prod_ext;
  logic signed [AccW-1:0]  addend;
  logic signed [AccW-1:0]  acc_d;
  logic signed [AccW-1:0]  acc_q;

  assign prod     = a_i * b_i;
  assign prod_ext = AccW'(prod);
  assign addend   = ctrl_i.shift_hi ? (prod_ext <<< IsumSplit) : prod_ext;
  assign acc_d    = (ctrl_i.clear ? '0 : acc_q) + addend;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en) begin
      acc_q <= acc_d;
    end
  end

  assign acc_o = acc_q;

endmodule

// ===== hw/rtl/wheel_speed_pid_unit.sv =====
// Top level of the wheel speed PID controller: sequencer, state and output register.
//
//   channel | direction | handshake             | payload
//   --------+-----------+-----------------------+-------------------------------------------
//   in      | input     | in_valid_i/in_ready_o | target_speed_i, steer_offset_i, pulse_count_i
//   out     | output    | out_valid_o/out_ready_i | duty_o, wheel_target_o, hit_high_o, hit_low_o
//   cfg     | input     | cfg_we_i              | cfg_idx_i, cfg_data_i
//
// From acceptance to a loaded result, an item makes five passes through the one 17x27
// multiply-accumulate unit plus error, divide and clamp steps.
// A new item is accepted whenever the sequencer is idle, also while a result waits.
// A stalled result holds the sequencer in its last step until the output register frees.
// Reset restores the register defaults and clears the integral and error history.
module wheel_speed_pid_unit #(
  parameter int unsigned ACC_BITS = 40
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [wsp_pkg::CfgIdxW-1:0]         cfg_idx_i,
  input  logic [wsp_pkg::CfgDataW-1:0]        cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [wsp_pkg::SpeedW-1:0]   target_speed_i,
  input  logic signed [wsp_pkg::SpeedW-1:0]   steer_offset_i,
  input  logic signed [wsp_pkg::SpeedW-1:0]   pulse_count_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [wsp_pkg::DutyW-1:0]           duty_o,
  output logic signed [wsp_pkg::TargetW-1:0]  wheel_target_o,
  output logic                                hit_high_o,
  output logic                                hit_low_o
);
  import wsp_pkg::*;

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_MEAS = 4'd1;
  localparam logic [3:0] ST_ERR  = 4'd2;
  localparam logic [3:0] ST_KP   = 4'd3;
  localparam logic [3:0] ST_KD   = 4'd4;
  localparam logic [3:0] ST_KILO = 4'd5;
  localparam logic [3:0] ST_KIHI = 4'd6;
  localparam logic [3:0] ST_DIV  = 4'd7;
  localparam logic [3:0] ST_OUT  = 4'd8;

  localparam logic signed [DiffW-1:0] ErrMax = DiffW'((64'sd1 <<< (ErrW - 1)) - 64'sd1);
  localparam logic signed [DiffW-1:0] ErrMin = -DiffW'(64'sd1 <<< (ErrW - 1));
  localparam logic signed [AccW-1:0]  IsumMax = (64'sd1 <<< (IsumW - 1)) - 64'sd1;
  localparam logic signed [AccW-1:0]  IsumMin = -(64'sd1 <<< (IsumW - 1));
  localparam logic signed [ACC_BITS-1:0] SumMax = {1'b0, {(ACC_BITS - 1){1'b1}}};
  localparam logic signed [ACC_BITS-1:0] SumMin = {1'b1, {(ACC_BITS - 1){1'b0}}};

  // configuration
  logic [GainW-1:0] prop_gain_q, integ_gain_q, deriv_gain_q, speed_scale_q;
  logic             offset_sign_q;
  logic [DutyW-1:0] duty_limit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prop_gain_q   <= GainW'(3500);
      integ_gain_q  <= GainW'(20);
      deriv_gain_q  <= '0;
      speed_scale_q <= GainW'(1114);
      offset_sign_q <= 1'b0;
      duty_limit_q  <= DutyW'(8000);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_PROP_GAIN:   prop_gain_q   <= cfg_data_i;
        CFG_INTEG_GAIN:  integ_gain_q  <= cfg_data_i;
        CFG_DERIV_GAIN:  deriv_gain_q  <= cfg_data_i;
        CFG_SPEED_SCALE: speed_scale_q <= cfg_data_i;
        CFG_OFFSET_SIGN: offset_sign_q <= cfg_data_i[0];
        CFG_DUTY_LIMIT:  duty_limit_q  <= cfg_data_i[DutyW-1:0];
        default: ;
      endcase
    end
  end

  // sequencer and datapath registers
  logic [3:0] state_q, state_d;
  logic       in_accept;
  logic       out_load;

  logic signed [TargetW-1:0]  wt_q, wt_d;
  logic signed [SpeedW-1:0]   cnt_q;
  logic signed [ErrW-1:0]     e_q;
  logic signed [D2W-1:0]      d2_q;
  logic signed [IsumW-1:0]    isum_q;
  logic signed [DriveW-1:0]   drive_q;
  logic signed [ACC_BITS-1:0] error_sum_q;
  logic signed [ErrW-1:0]     prev_error_q, prev_prev_error_q;

  mac_ctrl_t               mac_ctrl;
  logic signed [MacAW-1:0] mac_a;
  logic signed [MacBW-1:0] mac_b;
  logic signed [AccW-1:0]  acc;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_accept  = in_valid_i && in_ready_o;
  assign out_load   = (state_q == ST_OUT) && (!out_valid_o || out_ready_i);

  assign wt_d = offset_sign_q ? (TargetW'(target_speed_i) + TargetW'(steer_offset_i))
                              : (TargetW'(target_speed_i) - TargetW'(steer_offset_i));

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_accept) state_d = ST_MEAS;
      ST_MEAS: state_d = ST_ERR;
      ST_ERR:  state_d = ST_KP;
      ST_KP:   state_d = ST_KD;
      ST_KD:   state_d = ST_KILO;
      ST_KILO: state_d = ST_KIHI;
      ST_KIHI: state_d = ST_DIV;
      ST_DIV:  state_d = ST_OUT;
      ST_OUT:  if (out_load) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    mac_ctrl = '0;
    mac_a    = '0;
    mac_b    = '0;
    unique case (state_q)
      ST_MEAS: begin
        mac_ctrl = '{en: 1'b1, clear: 1'b1, shift_hi: 1'b0};
        mac_a    = MacAW'(cnt_q);
        mac_b    = $signed(MacBW'(speed_scale_q));
      end
      ST_KP: begin
        mac_ctrl = '{en: 1'b1, clear: 1'b1, shift_hi: 1'b0};
        mac_a    = $signed(MacAW'(prop_gain_q));
        mac_b    = MacBW'(e_q);
      end
      ST_KD: begin
        mac_ctrl = '{en: 1'b1, clear: 1'b0, shift_hi: 1'b0};
        mac_a    = $signed(MacAW'(deriv_gain_q));
        mac_b    = MacBW'(d2_q);
      end
      ST_KILO: begin
        mac_ctrl = '{en: 1'b1, clear: 1'b0, shift_hi: 1'b0};
        mac_a    = $signed(MacAW'(integ_gain_q));
        mac_b    = $signed(MacBW'(isum_q[IsumSplit-1:0]));
      end
      ST_KIHI: begin
        mac_ctrl = '{en: 1'b1, clear: 1'b0, shift_hi: 1'b1};
        mac_a    = $signed(MacAW'(integ_gain_q));
        mac_b    = MacBW'($signed(isum_q[IsumW-1:IsumSplit]));
      end
      default: ;
    endcase
  end

  wsp_mac u_mac (
    .clk_i  (clk_i),
    .ctrl_i (mac_ctrl),
    .a_i    (mac_a),
    .b_i    (mac_b),
    .acc_o  (acc)
  );

  // error, integral and second difference
  logic signed [MeasW-1:0]    meas;
  logic signed [DiffW-1:0]    diff;
  logic signed [ErrW-1:0]     err_sat;
  logic signed [ACC_BITS:0]   sum_ext;
  logic signed [ACC_BITS-1:0] sum_new;
  logic signed [AccW-1:0]     sum_wide;
  logic signed [IsumW-1:0]    isum_d;
  logic signed [D2W-1:0]      d2_d;

  always_comb begin
    meas = $signed(acc[MeasW+MeasShift-1:MeasShift]);
    diff = DiffW'(wt_q) - DiffW'(meas);
    if (diff > ErrMax) begin
      err_sat = ErrMax[ErrW-1:0];
    end else if (diff < ErrMin) begin
      err_sat = ErrMin[ErrW-1:0];
    end else begin
      err_sat = diff[ErrW-1:0];
    end
    sum_ext = (ACC_BITS + 1)'(error_sum_q) + (ACC_BITS + 1)'(err_sat);
    if (sum_ext[ACC_BITS] != sum_ext[ACC_BITS-1]) begin
      sum_new = sum_ext[ACC_BITS] ? SumMin : SumMax;
    end else begin
      sum_new = sum_ext[ACC_BITS-1:0];
    end
    sum_wide = AccW'(sum_new);
    if (sum_wide > IsumMax) begin
      isum_d = IsumMax[IsumW-1:0];
    end else if (sum_wide < IsumMin) begin
      isum_d = IsumMin[IsumW-1:0];
    end else begin
      isum_d = sum_wide[IsumW-1:0];
    end
    d2_d = D2W'(err_sat) - (D2W'(prev_error_q) <<< 1) + D2W'(prev_prev_error_q);
  end

  // truncate toward zero on the divide by 1024
  logic signed [AccW-1:0] acc_rnd;
  assign acc_rnd = acc + $signed({{(AccW - DivShift){1'b0}}, {DivShift{acc[AccW-1]}}});

  // clamp
  logic                     over_limit;
  logic                     below_zero;
  logic [DutyW-1:0]         duty_d;

  always_comb begin
    over_limit = drive_q > $signed({{(DriveW - DutyW){1'b0}}, duty_limit_q});
    below_zero = drive_q[DriveW-1];
    if (over_limit) begin
      duty_d = duty_limit_q;
    end else if (below_zero) begin
      duty_d = '0;
    end else begin
      duty_d = drive_q[DutyW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q           <= ST_IDLE;
      error_sum_q       <= '0;
      prev_error_q      <= '0;
      prev_prev_error_q <= '0;
      out_valid_o       <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_ERR) begin
        error_sum_q       <= sum_new;
        prev_prev_error_q <= prev_error_q;
        prev_error_q      <= err_sat;
      end
      if (out_load) begin
        out_valid_o <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_o <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      wt_q  <= wt_d;
      cnt_q <= pulse_count_i;
    end
    if (state_q == ST_ERR) begin
      e_q    <= err_sat;
      d2_q   <= d2_d;
      isum_q <= isum_d;
    end
    if (state_q == ST_DIV) begin
      drive_q <= acc_rnd[AccW-1:DivShift];
    end
    if (out_load) begin
      duty_o         <= duty_d;
      wheel_target_o <= wt_q;
      hit_high_o     <= over_limit;
      hit_low_o      <= below_zero;
    end
  end

  // checks
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> state_q == ST_MEAS && !in_ready_o)
    else $error("accepted item did not start the sequence");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(hit_high_o && hit_low_o))
    else $error("both clamp flags set");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> duty_o <= duty_limit_q)
    else $error("duty above limit");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_OUT && out_valid_o && !out_ready_i |=> state_q == ST_OUT)
    else $error("result overwrote a pending item");

endmodule
